// ===== rtl/ostst_pkg.sv =====
// Shared types and codes for the one-shot timer slot table.
package ostst_pkg;

    localparam int REQ_W   = 2;
    localparam int DELAY_W = 31;
    localparam int FTAG_W  = 16;
    localparam int FID_W   = 16;
    localparam int KIND_W  = 3;
    localparam int TIME_W  = 32;
    localparam int STEP_W  = 8;

    localparam logic [REQ_W-1:0] REQ_SCHED  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CANCEL = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TICK   = 2'd2;

    localparam logic [KIND_W-1:0] KIND_SCHEDULED = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FULL      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CANCELLED = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EXPIRED   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_TICK_DONE = 3'd5;

    localparam logic [STEP_W-1:0] STEP_RESET = 8'd1;

    typedef enum logic [1:0] {
        OP_SCHED,
        OP_CANCEL,
        OP_TICK
    } op_t;

    // classified command passed from front to back
    typedef struct packed {
        op_t               op;
        logic [DELAY_W-1:0] delay;
        logic [FTAG_W-1:0]  tag;
        logic [FID_W-1:0]   target;
    } cmd_t;

endpackage

// ===== rtl/ostst_if.sv =====
// Valid/ready channel interfaces for requests and results.
interface ostst_req_if;
    logic                        valid;
    logic                        ready;
    logic [ostst_pkg::REQ_W-1:0]   req_type;
    logic [ostst_pkg::DELAY_W-1:0] delay_ms;
    logic [ostst_pkg::FTAG_W-1:0]  handler_tag;
    logic [ostst_pkg::FID_W-1:0]   target_id;
    modport source (output valid, req_type, delay_ms, handler_tag, target_id, input ready);
    modport sink (input valid, req_type, delay_ms, handler_tag, target_id, output ready);
endinterface

interface ostst_res_if;
    logic                         valid;
    logic                         ready;
    logic [ostst_pkg::KIND_W-1:0] kind;
    logic [ostst_pkg::FID_W-1:0]  timer_id;
    logic [ostst_pkg::FTAG_W-1:0] expired_tag;
    logic                         last;
    modport source (output valid, kind, timer_id, expired_tag, last, input ready);
    modport sink (input valid, kind, timer_id, expired_tag, last, output ready);
endinterface

// ===== rtl/ostst_ram.sv =====
// Generic RAM with one write port and one registered read port.
module ostst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/ostst_front.sv =====
// Front end: accepts request items, classifies them, queues commands.
module ostst_front (
    input  logic              clk,
    input  logic              rst_n,
    ostst_req_if.sink         req,
    output logic              cmd_valid,
    input  logic              cmd_pop,
    output ostst_pkg::cmd_t   cmd
);
    import ostst_pkg::*;

    localparam int QD = 2;

    cmd_t       q_reg [QD];
    logic [0:0] wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push;
    cmd_t       c;

    assign req.ready = (cnt_reg != 2'(QD));
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rp_reg];

    always_comb
    begin
        c.delay  = req.delay_ms;
        c.tag    = req.handler_tag;
        c.target = req.target_id;
        case (req.req_type)
            REQ_SCHED:  c.op = OP_SCHED;
            REQ_CANCEL: c.op = OP_CANCEL;
            default:    c.op = OP_TICK;
        endcase
    end

    // undefined request codes are dropped here
    assign push = req.valid && req.ready && (req.req_type == REQ_SCHED
        || req.req_type == REQ_CANCEL || req.req_type == REQ_TICK);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (cmd_pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(cmd_pop);
        end
    end
endmodule

// ===== rtl/ostst_back.sv =====
// Back end: slot table, slot-by-slot scans, result register.
module ostst_back #(
    parameter int SLOTS    = 32,
    parameter int ID_BITS  = 16,
    parameter int TAG_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [ostst_pkg::STEP_W-1:0]  step,
    input  logic                          cmd_valid,
    output logic                          cmd_pop,
    input  ostst_pkg::cmd_t               cmd,
    ostst_res_if.source                   res
);
    import ostst_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TICK_ADV,
        S_TICK_RD,
        S_TICK_EVAL,
        S_OUT
    } state_t;

    state_t              state_reg;
    logic [SLOTS-1:0]    active_reg, idv_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [ID_BITS-1:0]  next_id_reg;
    logic [CW-1:0]       idx_reg;
    cmd_t                cur_reg;
    logic                done_after_reg;

    logic                o_valid_reg, o_last_reg;
    logic [KIND_W-1:0]   o_kind_reg;
    logic [FID_W-1:0]    o_id_reg;
    logic [FTAG_W-1:0]   o_tag_reg;

    // result staged here until the output register is free
    logic                p_last_reg;
    logic [KIND_W-1:0]   p_kind_reg;
    logic [FID_W-1:0]    p_id_reg;
    logic [FTAG_W-1:0]   p_tag_reg;
    logic                out_load;

    logic [SW-1:0]       ram_raddr, ram_waddr, idx_s;
    logic                ram_we;
    logic [TIME_W-1:0]   due_rd;
    logic [ID_BITS-1:0]  id_rd;
    logic [TAG_BITS-1:0] tag_rd;
    logic [TIME_W-1:0]   diff;
    logic [FID_W-1:0]    id_ext;

    assign idx_s     = idx_reg[SW-1:0];
    assign ram_raddr = idx_s;
    assign ram_waddr = idx_s;
    assign ram_we    = (state_reg == S_SCAN) && (cur_reg.op == OP_SCHED)
                       && (idx_reg != CW'(SLOTS)) && !active_reg[idx_s];

    ostst_ram #(.WIDTH(TIME_W), .DEPTH(SLOTS)) u_due (
        .clk(clk), .we(ram_we), .waddr(ram_waddr),
        .wdata(now_reg + TIME_W'(cur_reg.delay)), .raddr(ram_raddr), .rdata(due_rd));
    ostst_ram #(.WIDTH(ID_BITS), .DEPTH(SLOTS)) u_id (
        .clk(clk), .we(ram_we), .waddr(ram_waddr),
        .wdata(next_id_reg), .raddr(ram_raddr), .rdata(id_rd));
    ostst_ram #(.WIDTH(TAG_BITS), .DEPTH(SLOTS)) u_tag (
        .clk(clk), .we(ram_we), .waddr(ram_waddr),
        .wdata(TAG_BITS'(cur_reg.tag)), .raddr(ram_raddr), .rdata(tag_rd));

    assign diff   = due_rd - now_reg;
    assign id_ext = FID_W'(id_rd);

    assign res.valid       = o_valid_reg;
    assign res.kind        = o_kind_reg;
    assign res.timer_id    = o_id_reg;
    assign res.expired_tag = o_tag_reg;
    assign res.last        = o_last_reg;

    assign cmd_pop  = (state_reg == S_IDLE) && cmd_valid;
    assign out_load = (state_reg == S_OUT) && (!o_valid_reg || res.ready);

    // sched checks one slot per cycle in S_SCAN; cancel and tick visit each slot in
    // the S_TICK_RD/S_TICK_EVAL pair
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            active_reg     <= '0;
            idv_reg        <= '0;
            now_reg        <= '0;
            next_id_reg    <= '0;
            idx_reg        <= '0;
            cur_reg        <= '0;
            done_after_reg <= 1'b0;
            o_valid_reg    <= 1'b0;
            o_last_reg     <= 1'b0;
            o_kind_reg     <= KIND_SCHEDULED;
            o_id_reg       <= '0;
            o_tag_reg      <= '0;
            p_last_reg     <= 1'b0;
            p_kind_reg     <= KIND_SCHEDULED;
            p_id_reg       <= '0;
            p_tag_reg      <= '0;
        end
        else
        begin
            if (out_load)
            begin
                o_valid_reg <= 1'b1;
                o_kind_reg  <= p_kind_reg;
                o_id_reg    <= p_id_reg;
                o_tag_reg   <= p_tag_reg;
                o_last_reg  <= p_last_reg;
            end
            else if (res.ready)
            begin
                o_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cur_reg <= cmd;
                        idx_reg <= '0;
                        case (cmd.op)
                            OP_SCHED:  state_reg <= S_SCAN;
                            OP_TICK:   state_reg <= S_TICK_ADV;
                            default:   state_reg <= S_TICK_RD;
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (idx_reg == CW'(SLOTS))
                    begin
                        p_kind_reg <= KIND_FULL;
                        p_id_reg   <= '0;
                        p_tag_reg  <= '0;
                        p_last_reg <= 1'b1;
                        state_reg  <= S_OUT;
                    end
                    else if (!active_reg[idx_s])
                    begin
                        active_reg[idx_s] <= 1'b1;
                        idv_reg[idx_s]    <= 1'b1;
                        p_kind_reg  <= KIND_SCHEDULED;
                        p_id_reg    <= FID_W'(next_id_reg);
                        p_tag_reg   <= '0;
                        p_last_reg  <= 1'b1;
                        next_id_reg <= next_id_reg + 1'b1;
                        state_reg   <= S_OUT;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_TICK_ADV:
                begin
                    now_reg   <= now_reg + TIME_W'(step);
                    state_reg <= S_TICK_RD;
                end
                S_TICK_RD:
                begin
                    if (idx_reg == CW'(SLOTS))
                    begin
                        p_id_reg  <= '0;
                        p_tag_reg <= '0;
                        p_last_reg <= 1'b1;
                        if (cur_reg.op == OP_TICK)
                        begin
                            p_kind_reg <= KIND_TICK_DONE;
                        end
                        else
                        begin
                            p_kind_reg <= KIND_NOT_FOUND;
                            p_id_reg   <= cur_reg.target;
                        end
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_TICK_EVAL;
                    end
                end
                S_TICK_EVAL:
                begin
                    state_reg <= S_TICK_RD;
                    idx_reg   <= idx_reg + 1'b1;
                    if (cur_reg.op == OP_CANCEL)
                    begin
                        if (idv_reg[idx_s]
                            && id_rd == ID_BITS'(cur_reg.target))
                        begin
                            active_reg[idx_s] <= 1'b0;
                            idv_reg[idx_s]    <= 1'b0;
                            p_kind_reg <= KIND_CANCELLED;
                            p_id_reg   <= cur_reg.target;
                            p_tag_reg  <= '0;
                            p_last_reg <= 1'b1;
                            state_reg  <= S_OUT;
                        end
                    end
                    else if (active_reg[idx_s]
                             && (diff == '0 || diff[TIME_W-1]))
                    begin
                        active_reg[idx_s] <= 1'b0;
                        if (tag_rd != '0)
                        begin
                            p_kind_reg     <= KIND_EXPIRED;
                            p_id_reg       <= id_ext;
                            p_tag_reg      <= FTAG_W'(tag_rd);
                            p_last_reg     <= 1'b0;
                            done_after_reg <= 1'b1;
                            state_reg      <= S_OUT;
                        end
                    end
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        if (done_after_reg)
                        begin
                            done_after_reg <= 1'b0;
                            state_reg      <= S_TICK_RD;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/one_shot_timer_slot_table.sv =====
// One-shot timer slot table: a table of SLOTS timers, walked one slot at a
// time. Schedule searches for the lowest free slot; cancel and tick read
// the slot RAMs slot by slot through a read state and an evaluate state, and
// a tick pauses its walk for each expiry result. The slot walk in the back
// end sets the rate; a two-entry command queue lets requests be accepted
// while the back end is busy. Undefined request codes produce no results.
module one_shot_timer_slot_table #(
    parameter int SLOTS    = 32,
    parameter int ID_BITS  = 16,
    parameter int TAG_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [ostst_pkg::STEP_W-1:0] cfg_wdata,
    ostst_req_if.sink                    req,
    ostst_res_if.source                  res
);
    import ostst_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic              cmd_valid, cmd_pop;
    cmd_t              cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_RESET;
        end
        else if (cfg_we)
        begin
            step_reg <= cfg_wdata;
        end
    end

    ostst_front u_front (
        .clk(clk), .rst_n(rst_n), .req(req),
        .cmd_valid(cmd_valid), .cmd_pop(cmd_pop), .cmd(cmd));

    ostst_back #(.SLOTS(SLOTS), .ID_BITS(ID_BITS), .TAG_BITS(TAG_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .step(step_reg),
        .cmd_valid(cmd_valid), .cmd_pop(cmd_pop), .cmd(cmd), .res(res));
endmodule

// ===== rtl/ostst_checker.sv =====
// Port-level checker for the timer slot table, bound to the top level.
module ostst_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         res_valid,
    input logic                         res_ready,
    input logic [ostst_pkg::KIND_W-1:0] res_kind,
    input logic [ostst_pkg::FTAG_W-1:0] res_tag,
    input logic                         res_last
);
    import ostst_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_kind))
        else $error("result changed while stalled");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_last == (res_kind != KIND_EXPIRED)))
        else $error("last flag wrong for kind");

    a_tag: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind != KIND_EXPIRED |-> res_tag == '0)
        else $error("tag nonzero on non-expiry");

    a_exptag: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind == KIND_EXPIRED |-> res_tag != '0)
        else $error("expiry with zero tag");
endmodule

bind one_shot_timer_slot_table ostst_checker u_chk (
    .clk(clk), .rst_n(rst_n), .res_valid(res.valid), .res_ready(res.ready),
    .res_kind(res.kind), .res_tag(res.expired_tag), .res_last(res.last));

// ===== dv/ostst_tb_if.sv =====
// Interfaces for the timer table testbench live in the RTL; this file holds the result record type.
package ostst_tb_pkg;
    import ostst_pkg::*;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [FID_W-1:0]  timer_id;
        logic [FTAG_W-1:0] tag;
        logic              last;
    } timer_result_t;
endpackage

// ===== dv/tb.sv =====
// Testbench for the one-shot timer slot table: predictor, checker and directed, backpressure and random tests.
module tb;
    import ostst_pkg::*;
    import ostst_tb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 32;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [REQ_W-1:0] REQ_UNDEF = 2'd3;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [STEP_W-1:0] cfg_wdata;

    ostst_req_if req ();
    ostst_res_if res ();

    one_shot_timer_slot_table u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .req      (req.sink),
        .res      (res.source)
    );

    // predictor state
    logic              tmr_active [SLOTS];
    logic              tmr_id_ok  [SLOTS];
    logic [TIME_W-1:0] tmr_due    [SLOTS];
    logic [FID_W-1:0]  tmr_id     [SLOTS];
    logic [FTAG_W-1:0] tmr_tag    [SLOTS];
    logic [TIME_W-1:0] clock_ms;
    logic [FID_W-1:0]  id_counter;
    logic [STEP_W-1:0] step_ms;

    timer_result_t pending_results[$];
    int errors = 0;
    int idle_cycles = 0;
    bit rx_hold = 0;
    bit rx_calm = 0;
    bit tx_calm = 0;
    logic [FID_W-1:0] issued_ids[$];

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic void push_result(logic [KIND_W-1:0] k, logic [FID_W-1:0] id,
                                        logic [FTAG_W-1:0] tg, logic lst);
        timer_result_t r;
        r.kind = k; r.timer_id = id; r.tag = tg; r.last = lst;
        pending_results.push_back(r);
    endfunction

    function automatic void predict_timer(logic [REQ_W-1:0] rt, logic [DELAY_W-1:0] dly,
                                          logic [FTAG_W-1:0] tg, logic [FID_W-1:0] tgt);
        int i;
        logic [TIME_W-1:0] d;
        if (rt == REQ_SCHED)
        begin
            for (i = 0; i < SLOTS; i++)
                if (!tmr_active[i]) break;
            if (i == SLOTS)
            begin
                push_result(KIND_FULL, '0, '0, 1'b1);
                return;
            end
            tmr_active[i] = 1; tmr_id_ok[i] = 1;
            tmr_due[i] = clock_ms + {1'b0, dly};
            tmr_tag[i] = tg;
            tmr_id[i] = id_counter;
            push_result(KIND_SCHEDULED, id_counter, '0, 1'b1);
            issued_ids.push_back(id_counter);
            if (issued_ids.size() > 64) void'(issued_ids.pop_front());
            id_counter++;
        end
        else if (rt == REQ_CANCEL)
        begin
            for (i = 0; i < SLOTS; i++)
                if (tmr_id_ok[i] && tmr_id[i] == tgt) break;
            if (i == SLOTS)
                push_result(KIND_NOT_FOUND, tgt, '0, 1'b1);
            else
            begin
                tmr_active[i] = 0; tmr_id_ok[i] = 0;
                push_result(KIND_CANCELLED, tgt, '0, 1'b1);
            end
        end
        else if (rt == REQ_TICK)
        begin
            clock_ms += step_ms;
            for (i = 0; i < SLOTS; i++)
            begin
                if (!tmr_active[i]) continue;
                d = tmr_due[i] - clock_ms;
                if (d == 0 || d[TIME_W-1])
                begin
                    tmr_active[i] = 0;
                    if (tmr_tag[i] != 0) push_result(KIND_EXPIRED, tmr_id[i], tmr_tag[i], 1'b0);
                end
            end
            push_result(KIND_TICK_DONE, '0, '0, 1'b1);
        end
    endfunction

    // valid stays up after an accept; the next item or a drain decides what follows
    task automatic send_request(input logic [REQ_W-1:0] rt, input logic [DELAY_W-1:0] dly,
                                input logic [FTAG_W-1:0] tg, input logic [FID_W-1:0] tgt);
        while (!tx_calm && $urandom_range(99) < 36)
        begin
            req.valid <= 0;
            @(posedge clk);
        end
        req.valid <= 1; req.req_type <= rt; req.delay_ms <= dly;
        req.handler_tag <= tg; req.target_id <= tgt;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        predict_timer(rt, dly, tg, tgt);
    endtask

    task automatic wait_drained();
        req.valid <= 0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (2 * SLOTS + 20) @(posedge clk);
    endtask

    task automatic write_step(input logic [STEP_W-1:0] v);
        wait_drained();
        cfg_we <= 1; cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 0;
        step_ms = v;
    endtask

    function automatic logic [FID_W-1:0] pick_target();
        if (issued_ids.size() != 0 && $urandom_range(3) != 0)
            return issued_ids[$urandom_range(issued_ids.size() - 1)];
        return FID_W'($urandom);
    endfunction

    // directed: extremes, each request kind, full table, cancel after expiry
    task automatic test_directed();
        send_request(REQ_TICK, 0, 0, 0);
        send_request(REQ_SCHED, 0, 16'hFFFF, 0);
        send_request(REQ_SCHED, 31'h7FFF_FFFF, 16'h1, 0);
        send_request(REQ_SCHED, 1, 0, 0);
        send_request(REQ_SCHED, 2, 16'hA5A5, 0);
        send_request(REQ_TICK, 0, 0, 0);
        send_request(REQ_TICK, 0, 0, 0);
        send_request(REQ_CANCEL, 0, 0, 16'd0);
        send_request(REQ_CANCEL, 0, 0, 16'd3);
        send_request(REQ_CANCEL, 0, 0, 16'd1);
        send_request(REQ_CANCEL, 0, 0, 16'hFFFF);
        send_request(REQ_UNDEF, 31'h5555_5555, 16'h5555, 16'hAAAA);
        for (int i = 0; i < 33; i++) send_request(REQ_SCHED, 3, i[15:0] + 16'd1, 0);
        send_request(REQ_TICK, 0, 0, 0);
        write_step(8'd255);
        send_request(REQ_TICK, 0, 0, 0);
    endtask

    // receiver holds off while sender floods the queue
    task automatic test_backpressure();
        write_step(8'd0);
        rx_hold = 1;
        fork
            begin
                repeat (300) @(posedge clk);
                rx_hold = 0;
            end
            for (int i = 0; i < 10; i++)
                send_request(REQ_W'($urandom_range(2)), DELAY_W'($urandom_range(50)),
                             FTAG_W'($urandom), pick_target());
        join
        wait_drained();
    endtask

    task automatic test_random(input int count);
        logic [REQ_W-1:0] rt;
        logic [DELAY_W-1:0] dly;
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 3) begin tx_calm = 1; rx_calm = 1; end
            if (i == count / 2) begin tx_calm = 0; rx_calm = 0; end
            if (i % 120 == 60) write_step(STEP_W'($urandom_range(255)));
            case ($urandom_range(9))
                0, 1, 2, 3: rt = REQ_SCHED;
                4, 5:       rt = REQ_CANCEL;
                9:          rt = ($urandom_range(3) == 0) ? REQ_UNDEF : REQ_TICK;
                default:    rt = REQ_TICK;
            endcase
            dly = ($urandom_range(15) == 0) ? DELAY_W'($urandom)
                                            : DELAY_W'($urandom_range(600));
            send_request(rt, dly, ($urandom_range(5) == 0) ? 16'h0 : FTAG_W'($urandom),
                         pick_target());
        end
    endtask

    // result checker and receiver stalls
    always @(posedge clk)
    begin
        timer_result_t exp_r;
        if (rst_n)
        begin
            if (res.valid && res.ready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch($sformatf("unexpected result kind %0d", res.kind));
                else
                begin
                    exp_r = pending_results.pop_front();
                    if (res.kind !== exp_r.kind)
                        report_mismatch($sformatf("kind %0d exp %0d", res.kind, exp_r.kind));
                    if (res.timer_id !== exp_r.timer_id)
                        report_mismatch($sformatf("timer_id %0h exp %0h", res.timer_id,
                                                  exp_r.timer_id));
                    if (res.expired_tag !== exp_r.tag)
                        report_mismatch($sformatf("tag %0h exp %0h", res.expired_tag, exp_r.tag));
                    if (res.last !== exp_r.last)
                        report_mismatch($sformatf("last %0b exp %0b", res.last, exp_r.last));
                end
            end
            res.ready <= !rx_hold && (rx_calm || $urandom_range(99) >= 36);
        end
        else
        begin
            res.ready <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (res.valid && res.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** one_shot_timer_slot_table: FAILED **");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            tmr_active[i] = 0; tmr_id_ok[i] = 0;
            tmr_due[i] = 0; tmr_id[i] = 0; tmr_tag[i] = 0;
        end
        clock_ms = 0; id_counter = 0; step_ms = STEP_RESET;
        rst_n = 0; cfg_we = 0; cfg_wdata = '0;
        req.valid = 0; req.req_type = '0; req.delay_ms = '0;
        req.handler_tag = '0; req.target_id = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        test_directed();
        write_step(8'd1);
        test_backpressure();
        write_step(8'd7);
        test_random(420);
        wait_drained();
        if (errors == 0)
            $display("** one_shot_timer_slot_table: PASSED **");
        else
            $display("** one_shot_timer_slot_table: FAILED **");
        $finish;
    end
endmodule
